/* rtl/rpid_pkg.sv */
package rpid_pkg;

    localparam int MAX_READS_DEF = 65536;

    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;

    localparam int DIST_W = 18;
    localparam logic [DIST_W-1:0] DIST_MAX = 18'h1FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN = 18'h20000;

    localparam int IDX_W = 16;
    localparam int CNT_W = 15;

    localparam int TU_START = 0;
    localparam int TU_SMALL = 1;
    localparam int TU_DELTA = 2;
    localparam int S_TUSER_W = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_RANGE   = 2'd1,
        ERR_NO_FREE = 2'd2
    } err_t;

    typedef struct packed {
        logic accept;
        logic clr_run;
        logic skip;
        logic finish;
    } rpid_cmd_t;

    typedef struct packed {
        logic marked;
        logic epoch_full;
        logic clr_last;
        logic out_free;
    } rpid_status_t;

endpackage

/* rtl/rpid_ctrl.sv */
module rpid_ctrl
    import rpid_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_start,
    input  rpid_status_t status,
    output rpid_cmd_t    cmd,
    output logic         in_ready
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST
    } state_t;

    state_t state_reg, state_next;
    logic   after_start_reg, after_start_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd              = '0;
        state_next       = state_reg;
        after_start_next = after_start_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (status.clr_last)
                begin
                    state_next = after_start_reg ? ST_TEST : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.accept = 1'b1;
                    if (in_start && status.epoch_full)
                    begin
                        state_next       = ST_CLEAR;
                        after_start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST:
            begin
                if (status.marked)
                begin
                    cmd.skip = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            after_start_reg <= 1'b0;
            ready_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            after_start_reg <= after_start_next;
            ready_reg       <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

/* rtl/rpid_dp.sv */
module rpid_dp
    import rpid_pkg::*;
#(
    parameter int MAX_READS = MAX_READS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpid_cmd_t             cmd,
    output rpid_status_t          status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser
);

    localparam int CW = $clog2(MAX_READS + 1);
    localparam int AW = $clog2(MAX_READS);
    localparam int PW = ((CW > DIST_W - 1) ? CW : DIST_W - 1) + 1;

    logic [EPOCH_W-1:0] mem [MAX_READS];
    logic [EPOCH_W-1:0] mem_q;

    logic [CW-1:0]      cursor_reg, cursor_next;
    logic [AW-1:0]      clr_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [DIST_W-1:0]  ref_reg, last_reg;
    logic               matched_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               small_reg, use_delta_reg, swap_reg;
    logic [7:0]         small_off_reg, delta_reg;
    logic [15:0]        full_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   res_first_reg, res_second_reg;
    logic [CNT_W-1:0]   res_num_reg;
    err_t               res_err_reg;

    logic               at_end;
    logic [DIST_W:0]    dsum;
    logic [DIST_W-1:0]  delta_dist, pair_dist;
    logic               dist_pos;
    logic [PW-1:0]      partner;
    logic               bad;
    logic               wr_en;
    logic [IDX_W-1:0]   cur16, part16;
    logic               start_in;

    assign start_in = s_tuser[TU_START];
    assign at_end   = (cursor_reg >= CW'(MAX_READS));

    always_comb
    begin
        dsum = {ref_reg[DIST_W-1], ref_reg} + {{(DIST_W - 7){delta_reg[7]}}, delta_reg};
        if (dsum[DIST_W] != dsum[DIST_W-1])
        begin
            delta_dist = dsum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            delta_dist = dsum[DIST_W-1:0];
        end
        if (small_reg)
        begin
            pair_dist = DIST_W'(small_off_reg);
        end
        else if (use_delta_reg)
        begin
            pair_dist = delta_dist;
        end
        else
        begin
            pair_dist = DIST_W'(full_reg);
        end
    end

    assign dist_pos = !pair_dist[DIST_W-1] && (pair_dist != '0);
    assign partner  = PW'(cursor_reg) + PW'(pair_dist[DIST_W-2:0]);
    assign bad      = !dist_pos || (partner >= PW'(MAX_READS));
    assign wr_en    = cmd.finish && !at_end && !bad;
    assign cur16    = IDX_W'(cursor_reg);
    assign part16   = IDX_W'(partner);

    always_comb
    begin
        cursor_next = cursor_reg;
        if (cmd.accept && start_in)
        begin
            cursor_next = '0;
        end
        else if (cmd.skip || (cmd.finish && !at_end))
        begin
            cursor_next = cursor_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_run)
        begin
            mem[clr_reg] <= EPOCH_NONE;
        end
        else if (wr_en)
        begin
            mem[partner[AW-1:0]] <= epoch_reg;
        end
        mem_q <= mem[cursor_next[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            clr_reg       <= '0;
            epoch_reg     <= EPOCH_FIRST;
            ref_reg       <= '0;
            last_reg      <= '0;
            matched_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            if (cmd.clr_run)
            begin
                clr_reg <= status.clr_last ? '0 : clr_reg + AW'(1);
            end
            if (cmd.accept && start_in)
            begin
                epoch_reg   <= status.epoch_full ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
                ref_reg     <= '0;
                last_reg    <= '0;
                matched_reg <= 1'b0;
                cnt_reg     <= '0;
            end
            else if (cmd.finish && !at_end)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (!small_reg && use_delta_reg)
                begin
                    ref_reg     <= pair_dist;
                    last_reg    <= pair_dist;
                    matched_reg <= 1'b1;
                end
                else if (!small_reg)
                begin
                    if (!matched_reg || (ref_reg != last_reg))
                    begin
                        ref_reg <= pair_dist;
                    end
                    last_reg    <= pair_dist;
                    matched_reg <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            small_reg     <= s_tuser[TU_SMALL];
            use_delta_reg <= s_tuser[TU_DELTA];
            small_off_reg <= s_tdata[7:0];
            delta_reg     <= s_tdata[15:8];
            full_reg      <= s_tdata[31:16];
            swap_reg      <= s_tdata[32];
        end
        if (cmd.finish)
        begin
            res_num_reg <= cnt_reg;
            if (at_end)
            begin
                res_first_reg  <= '0;
                res_second_reg <= '0;
                res_err_reg    <= ERR_NO_FREE;
            end
            else if (bad)
            begin
                res_first_reg  <= cur16;
                res_second_reg <= '0;
                res_err_reg    <= ERR_RANGE;
            end
            else
            begin
                res_first_reg  <= swap_reg ? part16 : cur16;
                res_second_reg <= swap_reg ? cur16 : part16;
                res_err_reg    <= ERR_NONE;
            end
        end
    end

    assign status.marked     = !at_end && (mem_q == epoch_reg);
    assign status.epoch_full = (epoch_reg == EPOCH_LAST);
    assign status.clr_last   = (clr_reg == AW'(MAX_READS - 1));
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_num_reg, res_second_reg, res_first_reg};
    assign m_tuser  = res_err_reg;

endmodule

/* rtl/read_pair_index_decoder_core.sv */
// Decodes one pair record per input item into the two read indices of the pair, walking a
// read cursor over a per-set bitmap of paired reads held in an on-chip memory with one
// epoch tag per read. An item is accepted, then decided and emitted, with one skip step for
// each already-paired read the cursor skips; the skip is bound by one read of the tag
// memory per cycle. The output register lets the next item be accepted while a result
// waits. After reset, and again on every fifteenth start-of-set record (tag wrap), the
// block runs a clearing pass over all MAX_READS tags, during which no item is accepted.
module read_pair_index_decoder_core
    import rpid_pkg::*;
#(
    parameter int MAX_READS = MAX_READS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // small_offset[7:0], delta[15:8], wide_offset[31:16], swap_order[32], zero[39:33]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // start_of_set[0], offset_is_small[1], delta_is_used[2]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // first_read[15:0], second_read[31:16], pair_number[46:32], zero[47]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // error_code[1:0]
    output logic [M_TUSER_W-1:0]  m_tuser
);

    rpid_cmd_t    cmd;
    rpid_status_t status;

    rpid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_start (s_tuser[TU_START]),
        .status   (status),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    rpid_dp #(
        .MAX_READS (MAX_READS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in work");

    a_no_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ERR_NO_FREE) |-> (m_tdata[31:0] == 32'd0))
        else $error("no-free result carries read indices");

    a_range_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ERR_RANGE) |-> (m_tdata[31:16] == 16'd0))
        else $error("range error result carries a partner");

    a_code_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ERR_NONE) || (m_tuser == ERR_RANGE)
                     || (m_tuser == ERR_NO_FREE))
        else $error("unknown error code");

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rpid_pkg::*;

    localparam int READS = MAX_READS_DEF;
    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        bit         start;
        bit         is_small;
        logic [7:0] small_off;
        bit         use_delta;
        logic [7:0] delta;
        logic [15:0] full_off;
        bit         swap;
    } pair_rec_t;

    typedef struct {
        logic [IDX_W-1:0] first_read;
        logic [IDX_W-1:0] second_read;
        logic [CNT_W-1:0] pair_number;
        err_t             code;
    } pair_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    bit                   read_paired [READS];
    logic [16:0]          next_read;
    logic signed [DIST_W-1:0] ref_distance;
    logic signed [DIST_W-1:0] prev_distance;
    bit                   delta_chained;
    logic [CNT_W-1:0]     pairs_in_set;

    pair_result_t         expected_pairs [$];
    int                   mismatches = 0;
    int                   results_seen = 0;
    int                   idle_cycles = 0;
    bit                   pacing = 1'b1;

    read_pair_index_decoder_core #(
        .MAX_READS(READS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_set_state();
        read_paired = '{default: 1'b0};
        next_read = '0;
        ref_distance = '0;
        prev_distance = '0;
        delta_chained = 1'b0;
        pairs_in_set = '0;
    endfunction

    function automatic pair_result_t decode_pair(input pair_rec_t r);
        pair_result_t res;
        int pair_dist;
        int partner;
        if (r.start)
            clear_set_state();
        while (next_read < READS && read_paired[next_read])
            next_read++;
        res.pair_number = pairs_in_set;
        if (next_read >= READS)
        begin
            res.first_read = '0;
            res.second_read = '0;
            res.code = ERR_NO_FREE;
            return res;
        end
        if (r.is_small)
            pair_dist = int'(r.small_off);
        else if (r.use_delta)
        begin
            pair_dist = int'(ref_distance) + int'($signed(r.delta));
            if (pair_dist > int'($signed(DIST_MAX)))
                pair_dist = int'($signed(DIST_MAX));
            if (pair_dist < int'($signed(DIST_MIN)))
                pair_dist = int'($signed(DIST_MIN));
            ref_distance = pair_dist[DIST_W-1:0];
            prev_distance = pair_dist[DIST_W-1:0];
            delta_chained = 1'b1;
        end
        else
        begin
            pair_dist = int'(r.full_off);
            if (!delta_chained || ref_distance != prev_distance)
                ref_distance = pair_dist[DIST_W-1:0];
            delta_chained = 1'b0;
            prev_distance = pair_dist[DIST_W-1:0];
        end
        partner = int'(next_read) + pair_dist;
        if (pair_dist <= 0 || partner >= READS)
        begin
            res.first_read = next_read[IDX_W-1:0];
            res.second_read = '0;
            res.code = ERR_RANGE;
        end
        else
        begin
            read_paired[partner] = 1'b1;
            res.first_read = r.swap ? partner[IDX_W-1:0] : next_read[IDX_W-1:0];
            res.second_read = r.swap ? next_read[IDX_W-1:0] : partner[IDX_W-1:0];
            res.code = ERR_NONE;
        end
        read_paired[next_read] = 1'b1;
        next_read++;
        pairs_in_set++;
        return res;
    endfunction

    function automatic pair_rec_t noisy_rec(input bit start, input bit swap);
        pair_rec_t r;
        r.start = start;
        r.swap = swap;
        r.is_small = 1'b0;
        r.small_off = 8'($urandom);
        r.use_delta = 1'($urandom);
        r.delta = 8'($urandom);
        r.full_off = 16'($urandom);
        return r;
    endfunction

    function automatic pair_rec_t small_rec(input bit start, input int off, input bit swap);
        pair_rec_t r;
        r = noisy_rec(start, swap);
        r.is_small = 1'b1;
        r.small_off = off[7:0];
        return r;
    endfunction

    function automatic pair_rec_t delta_rec(input bit start, input int d, input bit swap);
        pair_rec_t r;
        r = noisy_rec(start, swap);
        r.use_delta = 1'b1;
        r.delta = d[7:0];
        return r;
    endfunction

    function automatic pair_rec_t full_rec(input bit start, input int off, input bit swap);
        pair_rec_t r;
        r = noisy_rec(start, swap);
        r.use_delta = 1'b0;
        r.full_off = off[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s is %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    task automatic send_record(input pair_rec_t r);
        int gap;
        gap = pacing ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, r.swap, r.full_off, r.delta, r.small_off};
        s_tuser <= {r.use_delta, r.is_small, r.start};
        do
            @(posedge clk);
        while (!s_tready);
        expected_pairs.insert(expected_pairs.size(), decode_pair(r));
    endtask

    task automatic check_result();
        pair_result_t want;
        if (expected_pairs.size() == 0)
        begin
            report_mismatch("unexpected item", m_tdata, 0);
            results_seen++;
            return;
        end
        want = expected_pairs.pop_front();
        if (m_tdata[15:0] != want.first_read)
            report_mismatch("first_read", m_tdata[15:0], want.first_read);
        if (m_tdata[31:16] != want.second_read)
            report_mismatch("second_read", m_tdata[31:16], want.second_read);
        if (m_tdata[46:32] != want.pair_number)
            report_mismatch("pair_number", m_tdata[46:32], want.pair_number);
        if (err_t'(m_tuser) != want.code)
            report_mismatch("error_code", m_tuser, want.code);
        results_seen++;
    endtask

    task automatic test_offset_extremes();
        send_record(small_rec(1, 0, 0));
        send_record(small_rec(0, 255, 1));
        send_record(small_rec(0, 1, 0));
        send_record(full_rec(0, 65535, 1));
        send_record(full_rec(0, 0, 0));
        send_record(full_rec(0, 1, 1));
        send_record(full_rec(1, 65535, 0));
        send_record(small_rec(0, 128, 1));
        send_record(delta_rec(0, -128, 1));
        send_record(delta_rec(0, 127, 0));
    endtask

    task automatic test_referential_chain();
        send_record(delta_rec(1, 10, 0));
        send_record(full_rec(0, 50, 1));
        send_record(delta_rec(0, 1, 0));
        send_record(full_rec(0, 40, 0));
        send_record(full_rec(0, 60, 1));
        send_record(delta_rec(0, -128, 0));
        send_record(delta_rec(0, 127, 1));
        send_record(delta_rec(0, 0, 0));
        send_record(full_rec(0, 70, 1));
    endtask

    task automatic test_partner_collisions();
        send_record(small_rec(1, 5, 0));
        send_record(small_rec(0, 3, 1));
        send_record(small_rec(0, 3, 0));
        send_record(small_rec(0, 1, 1));
        send_record(small_rec(0, 2, 0));
        send_record(small_rec(0, 1, 0));
        send_record(small_rec(0, 200, 1));
        send_record(small_rec(0, 1, 0));
    endtask

    // run enough set starts to wrap the epoch tags
    task automatic test_set_restarts();
        repeat (16)
            send_record(small_rec(1, $urandom_range(1, 255), $urandom_range(0, 1)));
    endtask

    task automatic test_delta_runs();
        pacing = 1'b0;
        send_record(full_rec(1, 65535, 0));
        repeat (20)
            send_record(delta_rec(0, 127, $urandom_range(0, 1)));
        repeat (20)
            send_record(delta_rec(0, -128, $urandom_range(0, 1)));
        send_record(full_rec(0, 20, 0));
        send_record(full_rec(0, 30, 1));
        send_record(delta_rec(0, 0, 0));
        pacing = 1'b1;
    endtask

    task automatic test_random_records();
        pair_rec_t r;
        bit start;
        bit swap;
        int d;
        for (int n = 0; n < 360; n++)
        begin
            pacing = ((n / 60) % 3) != 2;
            start = (n == 0) || ($urandom_range(0, 39) == 0);
            swap = $urandom_range(0, 1);
            case ($urandom_range(0, 3))
                0, 1:
                    r = small_rec(start, ($urandom_range(0, 7) == 0) ?
                                  $urandom_range(0, 255) : $urandom_range(1, 16), swap);
                2:
                begin
                    d = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 255)) - 128
                                                    : int'($urandom_range(0, 16)) - 8;
                    r = delta_rec(start, d, swap);
                end
                default:
                    r = full_rec(start, ($urandom_range(0, 3) == 0) ?
                                 $urandom_range(0, 65535) : $urandom_range(1, 64), swap);
            endcase
            send_record(r);
        end
        pacing = 1'b1;
    endtask

    initial
    begin : sink
        int stall;
        wait (rst_n);
        forever
        begin
            stall = pacing ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            check_result();
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clear_set_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_offset_extremes();
        test_referential_chain();
        test_partner_collisions();
        test_set_restarts();
        test_delta_runs();
        test_random_records();
        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rpid_pkg.sv
rtl/rpid_ctrl.sv
rtl/rpid_dp.sv
rtl/read_pair_index_decoder_core.sv
sim/testbench.sv
